>>> rtl/fem1d_pkg.sv
// ----------------------------------------------------------------------------
// fem1d_pkg
// shared types, constants and quadrature coefficient tables
// ----------------------------------------------------------------------------
`default_nettype none
package fem1d_pkg;

  localparam int SAMP_W   = 32;
  localparam int H_W      = 33;
  localparam int OUT_W    = 48;
  localparam int COEF_W   = 32;
  localparam int TAB_N    = 256;
  localparam int TAB_AW   = 8;
  // quotient bits kept by the stiffness divider, anything larger saturates
  localparam int DIV_BITS = 50;
  localparam int MAG_W    = 60;
  localparam int MASS_SH  = 49;

  localparam longint Q30_ONE  = 64'sd1073741824;
  localparam longint Q30_HALF = 64'sd536870912;
  localparam longint GP2      = 64'sd619925131;
  localparam longint GP3      = 64'sd831716840;
  localparam longint W59      = 64'sd596523236;
  localparam longint W89      = 64'sd954437177;

  localparam int KIND_K = 0;
  localparam int KIND_M = 1;
  localparam int KIND_F = 2;

  typedef logic signed [COEF_W-1:0] coef_tab_t [0:TAB_N-1];

  typedef struct packed {
    logic                   degen;
    logic [H_W-1:0]         h;
    logic [2:0][SAMP_W-1:0] a;
    logic [2:0][SAMP_W-1:0] q;
    logic [2:0][SAMP_W-1:0] f;
  } elem_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic       load;
    logic       degen;
    logic       last;
  } meta_t;

  function automatic longint rnd(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) << (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint xi_of(input int r, input int q);
    if (r == 0) return (q == 0) ? -GP2 : ((q == 1) ? GP2 : 64'sd0);
    return (q == 0) ? -GP3 : ((q == 2) ? GP3 : 64'sd0);
  endfunction

  function automatic longint w_of(input int r, input int q);
    if (r == 0) return (q < 2) ? Q30_ONE : 64'sd0;
    return (q == 1) ? W89 : ((q < 3) ? W59 : 64'sd0);
  endfunction

  function automatic longint phi_of(input int b, input longint xi, input int i);
    longint xx;
    xx = rnd(xi * xi, 30);
    if (b != 0) begin
      if (i == 0) return rnd(xx - xi, 1);
      if (i == 1) return rnd(xx + xi, 1);
      if (i == 2) return Q30_ONE - xx;
      return 64'sd0;
    end
    if (i == 0) return rnd(Q30_ONE - xi, 1);
    if (i == 1) return rnd(Q30_ONE + xi, 1);
    return 64'sd0;
  endfunction

  function automatic longint dphi_of(input int b, input longint xi, input int i);
    if (b != 0) begin
      if (i == 0) return xi - Q30_HALF;
      if (i == 1) return xi + Q30_HALF;
      if (i == 2) return -2 * xi;
      return 64'sd0;
    end
    if (i == 0) return -Q30_HALF;
    if (i == 1) return Q30_HALF;
    return 64'sd0;
  endfunction

  // index is {basis, rule, point, row, col}
  function automatic coef_tab_t build_tab(input int kind);
    coef_tab_t t;
    longint xi, w, v;
    for (int b = 0; b < 2; b++)
      for (int r = 0; r < 2; r++)
        for (int q = 0; q < 4; q++)
          for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++) begin
              xi = xi_of(r, q);
              w  = w_of(r, q);
              if (kind == KIND_K)
                v = rnd(rnd(dphi_of(b, xi, i) * dphi_of(b, xi, j), 30) * w, 36);
              else if (kind == KIND_M)
                v = rnd(rnd(phi_of(b, xi, i) * phi_of(b, xi, j), 30) * w, 36);
              else
                v = (j == 0) ? rnd(phi_of(b, xi, i) * w, 36) : 64'sd0;
              t[b*128 + r*64 + q*16 + i*4 + j] = v[COEF_W-1:0];
            end
    return t;
  endfunction

  localparam coef_tab_t KC_TAB = build_tab(KIND_K);
  localparam coef_tab_t MC_TAB = build_tab(KIND_M);
  localparam coef_tab_t FC_TAB = build_tab(KIND_F);

endpackage
`default_nettype wire

>>> rtl/fem_1d_element_matrix.sv
// ----------------------------------------------------------------------------
// fem_1d_element_matrix
// 1d finite element local matrix and load vector by gauss quadrature
// ----------------------------------------------------------------------------
// path: an accepted element beat passes the queue, the lookup, product, sum
//   and setup registers, the divider line and the output register
// throughput: one result beat per cycle unless out_tready stalls; an element
//   gives 6 beats (linear), 12 (quadratic) or 1 (degenerate), one per entry
// reset: rst_n synchronous active low, clears the queue, the pipeline valid
//   bits and both configuration registers (linear basis, two-point rule)
`default_nettype none
module fem_1d_element_matrix
  import fem1d_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration: 0 basis_order, 1 quad_rule
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic         cfg_wdata,
  // element beats
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // x_left, x_right, a_at_qp0..2, q_at_qp0..2, f_at_qp0..2, 32 bits each
  input  wire logic [351:0] in_tdata,
  // result beats
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // row_index[1:0], col_index[3:2], entry_value[51:4], zero pad[55:52]
  output logic [55:0]       out_tdata,
  // is_load[0], status[1]
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  localparam logic REG_BASIS = 1'b0;
  localparam logic REG_RULE  = 1'b1;

  logic basis_r, rule_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      basis_r <= 1'b0;
      rule_r  <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_addr == REG_BASIS) basis_r <= cfg_wdata;
      if (cfg_addr == REG_RULE)  rule_r  <= cfg_wdata;
    end
  end

  // front: length and degenerate check, straight into the queue
  logic  push, q_full, q_nonempty, q_pop;
  elem_t wr_elem, head;

  fem1d_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .elem      (wr_elem)
  );

  // queue lets the front keep taking elements while the back is stalled
  fem1d_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_elem  (wr_elem),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head)
  );

  // back: one entry a cycle while the output is not stalled, through sums, scaling and the stiffness divider
  fem1d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .basis      (basis_r),
    .rule       (rule_r),
    .q_valid    (q_nonempty),
    .head       (head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

>>> rtl/fem1d_front.sv
// ----------------------------------------------------------------------------
// fem1d_front
// accepts element beats, forms the element length and flags degenerate ones
// ----------------------------------------------------------------------------
`default_nettype none
module fem1d_front
  import fem1d_pkg::*;
(
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [351:0] in_tdata,
  input  wire logic         q_full,
  output logic              push,
  output elem_t             elem
);

  logic signed [H_W-1:0] h_s;

  assign h_s = H_W'($signed(in_tdata[63:32])) - H_W'($signed(in_tdata[31:0]));

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    elem.degen = h_s[H_W-1] || (h_s == '0);
    elem.h     = h_s;
    for (int k = 0; k < 3; k++) begin
      elem.a[k] = in_tdata[64  + 32*k +: 32];
      elem.q[k] = in_tdata[160 + 32*k +: 32];
      elem.f[k] = in_tdata[256 + 32*k +: 32];
    end
  end

endmodule
`default_nettype wire

>>> rtl/fem1d_queue.sv
// ----------------------------------------------------------------------------
// fem1d_queue
// two-entry element queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module fem1d_queue
  import fem1d_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire elem_t wr_elem,
  input  wire logic  pop,
  output logic       full,
  output logic       nonempty,
  output elem_t      head
);

  elem_t      mem_r [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign nonempty = (cnt_r != 2'd0);
  assign head     = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_elem;
  end

endmodule
`default_nettype wire

>>> rtl/fem1d_back.sv
// ----------------------------------------------------------------------------
// fem1d_back
// entry sequencer and arithmetic pipeline: sums, scaling, divider, output
// ----------------------------------------------------------------------------
`default_nettype none
module fem1d_back
  import fem1d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        basis,
  input  wire logic        rule,
  input  wire logic        q_valid,
  input  wire elem_t       head,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,
  output logic [1:0]       out_tuser,
  output logic             out_tlast
);

  logic pipe_en;
  logic issue;

  // sequencer
  logic [1:0] row_r, col_r, row_nxt, col_nxt, nd_last;
  logic       load_r, load_nxt, last_entry;

  assign nd_last    = basis ? 2'd2 : 2'd1;
  assign last_entry = head.degen || (load_r && row_r == nd_last);
  assign issue      = q_valid && pipe_en;
  assign q_pop      = issue && last_entry;

  always_comb begin
    row_nxt  = row_r;
    col_nxt  = col_r;
    load_nxt = load_r;
    if (last_entry) begin
      row_nxt  = 2'd0;
      col_nxt  = 2'd0;
      load_nxt = 1'b0;
    end else if (load_r) begin
      row_nxt = row_r + 2'd1;
    end else if (col_r == nd_last) begin
      col_nxt = 2'd0;
      if (row_r == nd_last) begin
        row_nxt  = 2'd0;
        load_nxt = 1'b1;
      end else begin
        row_nxt = row_r + 2'd1;
      end
    end else begin
      col_nxt = col_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= 2'd0;
      col_r  <= 2'd0;
      load_r <= 1'b0;
    end else if (issue) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      load_r <= load_nxt;
    end
  end

  // stage 1: coefficient lookup and sample select
  logic                     v1_r;
  meta_t                    m1_r;
  logic [H_W-1:0]           h1_r;
  logic [2:0][SAMP_W-1:0]   sk1_r, sm1_r, ck1_r, cm1_r;
  logic [2:0][SAMP_W-1:0]   sm_nxt, ck_nxt, cm_nxt;
  logic [2:0][TAB_AW-1:0]   idx;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      idx[k]    = {basis, rule, 2'(k), row_r, load_r ? 2'd0 : col_r};
      ck_nxt[k] = load_r ? '0 : KC_TAB[idx[k]];
      cm_nxt[k] = load_r ? FC_TAB[idx[k]] : MC_TAB[idx[k]];
      sm_nxt[k] = load_r ? head.f[k] : head.q[k];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m1_r  <= '{row: row_r, col: load_r ? 2'd0 : col_r, load: load_r,
                 degen: head.degen, last: last_entry};
      h1_r  <= head.h;
      sk1_r <= head.a;
      sm1_r <= sm_nxt;
      ck1_r <= ck_nxt;
      cm1_r <= cm_nxt;
    end
  end

  // stage 2: products
  logic                     v2_r;
  meta_t                    m2_r;
  logic [H_W-1:0]           h2_r;
  logic signed [63:0]       pk2_r [0:2];
  logic signed [63:0]       pm2_r [0:2];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m2_r <= m1_r;
      h2_r <= h1_r;
      for (int k = 0; k < 3; k++) begin
        pk2_r[k] <= $signed(sk1_r[k]) * $signed(ck1_r[k]);
        pm2_r[k] <= $signed(sm1_r[k]) * $signed(cm1_r[k]);
      end
    end
  end

  // stage 3: sums over the quadrature points
  logic                     v3_r;
  meta_t                    m3_r;
  logic [H_W-1:0]           h3_r;
  logic signed [63:0]       sk3_r, sm3_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m3_r  <= m2_r;
      h3_r  <= h2_r;
      sk3_r <= pk2_r[0] + pk2_r[1] + pk2_r[2];
      sm3_r <= pm2_r[0] + pm2_r[1] + pm2_r[2];
    end
  end

  // stage 4: magnitudes, mass partial products, divider setup
  logic                     v4_r;
  meta_t                    m4_r;
  logic [H_W-1:0]           h4_r;
  logic                     kneg4_r, mneg4_r, ovf4_r;
  logic [H_W-1:0]           r4_r;
  logic [DIV_BITS-1:0]      nb4_r;
  logic [62:0]              plo4_r, phi4_r;
  logic [63:0]              km_full, mm_full;
  logic [MAG_W-1:0]         km, mm;

  assign km_full = sk3_r[63] ? 64'(-sk3_r) : 64'(sk3_r);
  assign mm_full = sm3_r[63] ? 64'(-sm3_r) : 64'(sm3_r);
  assign km      = km_full[MAG_W-1:0];
  assign mm      = mm_full[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m4_r    <= m3_r;
      h4_r    <= h3_r;
      kneg4_r <= sk3_r[63];
      mneg4_r <= sm3_r[63];
      // stiffness quotient 2|sk|/h beyond the kept bits saturates anyway
      ovf4_r  <= H_W'(km[MAG_W-1:MASS_SH]) >= h3_r;
      r4_r    <= H_W'(km[MAG_W-1:MASS_SH]);
      nb4_r   <= {km[MASS_SH-1:0], 1'b0};
      plo4_r  <= 63'(mm[29:0]) * 63'(h3_r);
      phi4_r  <= 63'(mm[MAG_W-1:30]) * 63'(h3_r);
    end
  end

  // stage 5: rounded mass or load part
  logic [92:0]              msum;
  logic signed [45:0]       mass5;

  assign msum  = {phi4_r, 30'd0} + 93'(plo4_r) + (93'd1 << (MASS_SH - 1));
  assign mass5 = mneg4_r ? -$signed({2'b00, msum[92:MASS_SH]})
                         :  $signed({2'b00, msum[92:MASS_SH]});

  // divider line, one quotient bit per stage
  logic                     dv_r    [0:DIV_BITS];
  meta_t                    dm_r    [0:DIV_BITS];
  logic [H_W-1:0]           dh_r    [0:DIV_BITS];
  logic [H_W-1:0]           dr_r    [0:DIV_BITS];
  logic [DIV_BITS-1:0]      dq_r    [0:DIV_BITS];
  logic [DIV_BITS-1:0]      dnb_r   [0:DIV_BITS];
  logic signed [45:0]       dmass_r [0:DIV_BITS];
  logic                     dkneg_r [0:DIV_BITS];
  logic                     dovf_r  [0:DIV_BITS];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      dm_r[0]    <= m4_r;
      dh_r[0]    <= h4_r;
      dr_r[0]    <= r4_r;
      dq_r[0]    <= '0;
      dnb_r[0]   <= nb4_r;
      dmass_r[0] <= mass5;
      dkneg_r[0] <= kneg4_r;
      dovf_r[0]  <= ovf4_r;
    end
  end

  for (genvar s = 0; s < DIV_BITS; s++) begin : g_div
    logic [H_W:0] trial;
    logic         ge;
    assign trial = {dr_r[s], dnb_r[s][DIV_BITS-1]};
    assign ge    = trial >= {1'b0, dh_r[s]};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[s+1] <= 1'b0;
      end else if (pipe_en) begin
        dv_r[s+1] <= dv_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (pipe_en) begin
        dm_r[s+1]    <= dm_r[s];
        dh_r[s+1]    <= dh_r[s];
        dr_r[s+1]    <= ge ? H_W'(trial - {1'b0, dh_r[s]}) : trial[H_W-1:0];
        dq_r[s+1]    <= {dq_r[s][DIV_BITS-2:0], ge};
        dnb_r[s+1]   <= {dnb_r[s][DIV_BITS-2:0], 1'b0};
        dmass_r[s+1] <= dmass_r[s];
        dkneg_r[s+1] <= dkneg_r[s];
        dovf_r[s+1]  <= dovf_r[s];
      end
    end
  end

  // final: round quotient, sign, add mass, saturate, zero degenerate entries
  localparam int FIN = DIV_BITS;
  logic [DIV_BITS:0]        stiff_mag;
  logic signed [52:0]       stiff_s;
  logic signed [53:0]       total;
  logic signed [OUT_W-1:0]  sat_val, val_nxt;
  logic                     rup;

  assign rup       = {dr_r[FIN], 1'b0} >= {1'b0, dh_r[FIN]};
  assign stiff_mag = dovf_r[FIN] ? (DIV_BITS+1)'(1) << DIV_BITS
                                 : (DIV_BITS+1)'(dq_r[FIN]) + (DIV_BITS+1)'(rup);
  assign stiff_s   = dkneg_r[FIN] ? -$signed({2'b00, stiff_mag})
                                  :  $signed({2'b00, stiff_mag});
  assign total     = 54'(stiff_s) + 54'(dmass_r[FIN]);

  always_comb begin
    if (total > 54'sd140737488355327)       sat_val = {1'b0, {(OUT_W-1){1'b1}}};
    else if (total < -54'sd140737488355328) sat_val = {1'b1, {(OUT_W-1){1'b0}}};
    else                                    sat_val = total[OUT_W-1:0];
    val_nxt = dm_r[FIN].degen ? '0 : sat_val;
  end

  logic out_valid_r;
  assign pipe_en    = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      dv_r[0]     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r        <= q_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      dv_r[0]     <= v4_r;
      out_valid_r <= dv_r[FIN];
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tdata <= {4'd0, val_nxt,
                    dm_r[FIN].degen ? 2'd0 : dm_r[FIN].col,
                    dm_r[FIN].degen ? 2'd0 : dm_r[FIN].row};
      out_tuser <= {dm_r[FIN].degen, dm_r[FIN].load && !dm_r[FIN].degen};
      out_tlast <= dm_r[FIN].last;
    end
  end

endmodule
`default_nettype wire
